@@ hw/rtl/mwf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types and constants of the median window filter.
// ----------------------------------------------------------------------------
package mwf_pkg;

	localparam int DEF_MAX_APERTURE = 2;
	localparam int DEF_MAX_WIDTH    = 1024;

	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int WIDTH_W = 11;
	localparam int APER_W  = 2;
	localparam int CFG_W   = 11;

	typedef logic [PIX_W-1:0] pixel_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_PADDED_WIDTH = 1'b0,
		REG_APERTURE     = 1'b1
	} reg_index_t;

	localparam logic [WIDTH_W-1:0] RST_PADDED_WIDTH = WIDTH_W'(640);
	localparam logic [APER_W-1:0]  RST_APERTURE     = APER_W'(1);

endpackage

@@ hw/rtl/mwf_line_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_line_buf
// Line buffers holding the previous rows, one memory per line, shifted at the
// column of each pixel.
// ----------------------------------------------------------------------------
module mwf_line_buf
	import mwf_pkg::*;
#(
	parameter int LINES = 4,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  pixel_t          wr_pix,
	output pixel_t [LINES-1:0] rd_data
);

	pixel_t [LINES-1:0] rd_q;
	pixel_t [LINES-1:0] wdata;
	logic [PIX_W-1:0]   mem_q [LINES][DEPTH];

	// Line 0 takes the new pixel, every older line takes the line above it.
	always_comb begin
		wdata[0] = wr_pix;
		for (int k = 1; k < LINES; k++) begin
			wdata[k] = rd_q[k-1];
		end
	end

	// Registered read of every line; a write to the same column in the same cycle
	// is forwarded.
	always_ff @(posedge clk) begin
		for (int k = 0; k < LINES; k++) begin
			if (wr_en) begin
				mem_q[k][wr_addr] <= wdata[k];
			end
			if (rd_en) begin
				if (wr_en && (wr_addr == rd_addr)) begin
					rd_q[k] <= wdata[k];
				end else begin
					rd_q[k] <= mem_q[k][rd_addr];
				end
			end
		end
	end

	assign rd_data = rd_q;

endmodule

@@ hw/rtl/mwf_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_cell
// One column of the sliding window; passes its column to the next cell on
// every shift.
// ----------------------------------------------------------------------------
module mwf_cell
	import mwf_pkg::*;
#(
	parameter int SIDE = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  pixel_t [SIDE-1:0] col_in,
	output pixel_t [SIDE-1:0] col_out
);

	pixel_t [SIDE-1:0] col_q;

	// Load the neighbour's column when a pixel moves through the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

@@ hw/rtl/mwf_rank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_rank
// Median of one colour channel by ranking: pairwise compares, then counts,
// then selection of the element whose rank is the middle one.
// ----------------------------------------------------------------------------
module mwf_rank
	import mwf_pkg::*;
#(
	parameter int NE  = 25,
	parameter int RKW = $clog2(NE)
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [NE-1:0][CH_W-1:0]  vals,
	input  logic [NE-1:0]            act,
	input  logic [RKW-1:0]           mid,
	output logic [CH_W-1:0]          med
);

	logic [NE-1:0][NE-1:0]   lt_d;
	logic [NE-1:0][NE-1:0]   lt_s3;
	logic [NE-1:0][CH_W-1:0] val_s3;
	logic [NE-1:0]           act_s3;
	logic [RKW-1:0]          mid_s3;
	logic [NE-1:0]           sel_d;
	logic [NE-1:0]           sel_s4;
	logic [NE-1:0][CH_W-1:0] val_s4;

	// Element j is ranked below element i if smaller, or equal and earlier.
	always_comb begin
		for (int i = 0; i < NE; i++) begin
			for (int j = 0; j < NE; j++) begin
				lt_d[i][j] = act[j] && ((vals[j] < vals[i]) ||
					((vals[j] == vals[i]) && (j < i)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lt_s3  <= lt_d;
			val_s3 <= vals;
			act_s3 <= act;
			mid_s3 <= mid;
		end
	end

	// Exactly one active element carries the middle rank.
	always_comb begin
		for (int i = 0; i < NE; i++) begin
			sel_d[i] = act_s3[i] && (RKW'($countones(lt_s3[i])) == mid_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s4 <= sel_d;
			val_s4 <= val_s3;
		end
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < NE; i++) begin
			med = med | (val_s4[i] & {CH_W{sel_s4[i]}});
		end
	end

endmodule

@@ hw/rtl/median_window_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_window_filter
// Per-channel 2-D median over a square window sliding across a padded RGB
// image in raster order, with line buffers and a row of window cells.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  start_of_frame, in_red, in_green, in_blue
//  out      out_valid/out_stall  median_red, median_green, median_blue
//  cfg      cfg_we               cfg_index, cfg_data
//
// One pixel is taken every clock while in_stall is low. out_valid follows the
// pixel's transfer through line-buffer read at the transfer, then window shift,
// compare, rank count and output register.
// Reset clears counters, window and valid flags; line buffers are not cleared.
// A stalled output is backed by a one-entry skid; in_stall rises only once
// the skid holds a result, and then the whole pipeline holds.
// ----------------------------------------------------------------------------
module median_window_filter
	import mwf_pkg::*;
#(
	parameter int MAX_APERTURE = DEF_MAX_APERTURE,
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               start_of_frame,
	input  logic [CH_W-1:0]    in_red,
	input  logic [CH_W-1:0]    in_green,
	input  logic [CH_W-1:0]    in_blue,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CH_W-1:0]    median_red,
	output logic [CH_W-1:0]    median_green,
	output logic [CH_W-1:0]    median_blue
);

	localparam int SIDE_MAX = 2 * MAX_APERTURE + 1;
	localparam int LINES    = 2 * MAX_APERTURE;
	localparam int NE       = SIDE_MAX * SIDE_MAX;
	localparam int RKW      = $clog2(NE);
	localparam int AW       = $clog2(MAX_WIDTH);
	localparam int CNTW     = $clog2(MAX_WIDTH + 1);
	localparam int RW       = $clog2(SIDE_MAX + 1);

	logic [WIDTH_W-1:0] width_q;
	logic [APER_W-1:0]  aper_q;
	logic [AW-1:0]      col_q;
	logic [RW-1:0]      row_q;

	logic [CNTW-1:0]    w_eff;
	logic [APER_W-1:0]  a_eff;
	logic [RW-1:0]      n_side;
	logic [RW-1:0]      twice_a;
	logic [5:0]         nn;
	logic [RKW-1:0]     mid;

	logic               en;
	logic               accept;
	logic [AW-1:0]      col_cur;
	logic [RW-1:0]      row_cur;
	logic [AW-1:0]      col_nxt;
	logic [RW-1:0]      row_nxt;
	logic [CNTW-1:0]    col_inc;
	logic               emit;

	logic               val_s1_q;
	logic               val_s2_q;
	logic               val_s3_q;
	logic               val_s4_q;
	pixel_t             pix_s1;
	logic [AW-1:0]      col_s1;
	logic               emit_s1;

	pixel_t [LINES-1:0]    rd_data;
	pixel_t [SIDE_MAX-1:0] colv;
	pixel_t [SIDE_MAX-1:0] win [SIDE_MAX];
	logic                  shift;

	logic [NE-1:0][CH_W-1:0] vr;
	logic [NE-1:0][CH_W-1:0] vg;
	logic [NE-1:0][CH_W-1:0] vb;
	logic [NE-1:0]           act;
	logic [CH_W-1:0]         med_r;
	logic [CH_W-1:0]         med_g;
	logic [CH_W-1:0]         med_b;

	logic                    out_valid_q;
	logic                    skid_valid_q;
	logic [PIX_W-1:0]        out_q;
	logic [PIX_W-1:0]        skid_q;
	logic                    res_valid;
	logic                    out_take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_PADDED_WIDTH;
			aper_q  <= RST_APERTURE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PADDED_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
				REG_APERTURE:     aper_q  <= cfg_data[APER_W-1:0];
				default:          ;
			endcase
		end
	end

	// Effective geometry, saturated into the supported ranges.
	always_comb begin
		if (width_q == '0) begin
			w_eff = CNTW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = CNTW'(MAX_WIDTH);
		end else begin
			w_eff = CNTW'(width_q);
		end
		if (aper_q == '0) begin
			a_eff = APER_W'(1);
		end else if (int'(aper_q) > MAX_APERTURE) begin
			a_eff = APER_W'(MAX_APERTURE);
		end else begin
			a_eff = aper_q;
		end
		twice_a = RW'({a_eff, 1'b0});
		n_side  = twice_a + RW'(1);
		nn      = 6'(n_side) * 6'(n_side);
		mid     = RKW'((nn - 6'd1) >> 1);
	end

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && en;

	// Column and row position of the incoming pixel and of the next one.
	always_comb begin
		col_cur = start_of_frame ? '0 : col_q;
		row_cur = start_of_frame ? '0 : row_q;
		if (CNTW'(col_cur) >= w_eff) begin
			col_cur = '0;
			if (row_cur < n_side) begin
				row_cur = row_cur + RW'(1);
			end
		end
		emit    = (row_cur >= twice_a) && (col_cur >= AW'(twice_a));
		col_inc = CNTW'(col_cur) + CNTW'(1);
		row_nxt = row_cur;
		if (col_inc >= w_eff) begin
			col_nxt = '0;
			if (row_nxt < n_side) begin
				row_nxt = row_nxt + RW'(1);
			end
		end else begin
			col_nxt = col_inc[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// Valid flags of the pipeline stages; only pixels that complete a window go on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1_q <= 1'b0;
			val_s2_q <= 1'b0;
			val_s3_q <= 1'b0;
			val_s4_q <= 1'b0;
		end else if (en) begin
			val_s1_q <= accept;
			val_s2_q <= val_s1_q && emit_s1;
			val_s3_q <= val_s2_q;
			val_s4_q <= val_s3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= {in_red, in_green, in_blue};
			col_s1  <= col_cur;
			emit_s1 <= emit;
		end
	end

	mwf_line_buf #(
		.LINES (LINES),
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.wr_en   (shift),
		.wr_addr (col_s1),
		.wr_pix  (pix_s1),
		.rd_data (rd_data)
	);

	// New window column: the fresh pixel on top of the buffered rows.
	always_comb begin
		colv[0] = pix_s1;
		for (int k = 0; k < LINES; k++) begin
			colv[k+1] = rd_data[k];
		end
	end

	assign shift = val_s1_q && en;

	for (genvar c = 0; c < SIDE_MAX; c++) begin : g_cell
		if (c == 0) begin : g_head
			mwf_cell #(.SIDE(SIDE_MAX)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.col_in  (colv),
				.col_out (win[c])
			);
		end else begin : g_body
			mwf_cell #(.SIDE(SIDE_MAX)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.col_in  (win[c-1]),
				.col_out (win[c])
			);
		end
	end

	// Split the window into channels and mark the elements inside the aperture.
	always_comb begin
		for (int c = 0; c < SIDE_MAX; c++) begin
			for (int r = 0; r < SIDE_MAX; r++) begin
				vr[c*SIDE_MAX+r]  = win[c][r][PIX_W-1:2*CH_W];
				vg[c*SIDE_MAX+r]  = win[c][r][2*CH_W-1:CH_W];
				vb[c*SIDE_MAX+r]  = win[c][r][CH_W-1:0];
				act[c*SIDE_MAX+r] = (RW'(c) < n_side) && (RW'(r) < n_side);
			end
		end
	end

	mwf_rank #(.NE(NE), .RKW(RKW)) u_rank_r (
		.clk (clk), .en (en), .vals (vr), .act (act), .mid (mid), .med (med_r)
	);
	mwf_rank #(.NE(NE), .RKW(RKW)) u_rank_g (
		.clk (clk), .en (en), .vals (vg), .act (act), .mid (mid), .med (med_g)
	);
	mwf_rank #(.NE(NE), .RKW(RKW)) u_rank_b (
		.clk (clk), .en (en), .vals (vb), .act (act), .mid (mid), .med (med_b)
	);

	// Output register backed by a skid entry.
	assign res_valid = val_s4_q && en;
	assign out_take  = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= {med_r, med_g, med_b};
			end
		end else if (res_valid) begin
			skid_q <= {med_r, med_g, med_b};
		end
	end

	assign out_valid    = out_valid_q;
	assign median_red   = out_q[PIX_W-1:2*CH_W];
	assign median_green = out_q[2*CH_W-1:CH_W];
	assign median_blue  = out_q[CH_W-1:0];

endmodule
